// ----- rtl/asn_pkg.sv -----
// Shared types, constants and binary32 helper functions for the approximate square root.
// Used by asn_fp_unit and approx_sqrt_newton; depends on nothing else.
`default_nettype none

package asn_pkg;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_SUB,
      OP_DIV
   } op_kind_type;

   localparam logic [31:0] MAGIC_EST       = 32'h5F375A86;
   localparam logic [31:0] FP_HALF         = 32'h3F000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
   localparam logic [31:0] FP_ONE          = 32'h3F800000;
   localparam logic [31:0] FP_DEFAULT_NAN  = 32'hFFC00000;
   localparam logic [31:0] FP_QUIET_BIT    = 32'h00400000;

   // two quotient bits per stage, 26 bits in all
   localparam int DIV_STAGES = 13;

   typedef logic signed [10:0] exp_type;

   typedef struct packed {
      logic        sgn;
      exp_type     e;
      logic [23:0] sig;
      logic        zero;
      logic        inf;
      logic        nan;
   } unp_type;

   typedef struct packed {
      logic        spec;
      logic [31:0] spec_val;
      logic        sgn;
      exp_type     e;
      logic [25:0] m;
   } rnd_type;

   typedef struct packed {
      logic        zin;
      logic [31:0] xh;
      logic [31:0] y;
   } side_type;

   typedef struct packed {
      logic        spec;
      logic [31:0] spec_val;
      logic        sgn;
      exp_type     e;
      logic [23:0] dsr;
      logic [24:0] rem;
      logic [25:0] q;
   } dvs_type;

   // Unpack with subnormals normalised so that sig[23] is set for any nonzero value.
   function automatic unp_type fp_unpack(input logic [31:0] bits);
      unp_type     u;
      logic [4:0]  lz;
      logic [7:0]  ef;
      logic [22:0] f;
      ef = bits[30:23];
      f  = bits[22:0];
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (f[i]) lz = 5'(22 - i);
      end
      u.sgn  = bits[31];
      u.zero = (ef == 8'd0) && (f == 23'd0);
      u.inf  = (ef == 8'hFF) && (f == 23'd0);
      u.nan  = (ef == 8'hFF) && (f != 23'd0);
      if (ef == 8'd0) begin
         u.sig = 24'({1'b0, f} << (lz + 5'd1));
         u.e   = -11'sd127 - exp_type'({6'd0, lz});
      end else begin
         u.sig = {1'b1, f};
         u.e   = exp_type'({3'd0, ef}) - 11'sd127;
      end
      return u;
   endfunction

   function automatic logic [4:0] lzc28(input logic [27:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 28; i++) begin
         if (v[i]) n = 5'(27 - i);
      end
      return n;
   endfunction

   // Special operands; bit 32 flags a result that bypasses the datapath.
   function automatic logic [32:0] fp_special(input op_kind_type op,
                                              input logic [31:0] a,
                                              input logic [31:0] b,
                                              input unp_type ua,
                                              input unp_type ub);
      logic        sx;
      logic        nbs;
      logic [32:0] r;
      sx  = ua.sgn ^ ub.sgn;
      nbs = ~ub.sgn;
      r   = 33'd0;
      if (ua.nan) begin
         r = {1'b1, a | FP_QUIET_BIT};
      end else if (ub.nan) begin
         r = {1'b1, b | FP_QUIET_BIT};
      end else begin
         case (op)
            OP_MUL: begin
               if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) r = {1'b1, FP_DEFAULT_NAN};
               else if (ua.inf || ub.inf)                      r = {1'b1, sx, 8'hFF, 23'd0};
               else if (ua.zero || ub.zero)                    r = {1'b1, sx, 31'd0};
            end
            OP_SUB: begin
               if (ua.inf && ub.inf && (ua.sgn != nbs)) r = {1'b1, FP_DEFAULT_NAN};
               else if (ua.inf)                         r = {1'b1, a};
               else if (ub.inf)                         r = {1'b1, nbs, 8'hFF, 23'd0};
               else if (ua.zero && ub.zero)             r = {1'b1, ua.sgn & nbs, 31'd0};
               else if (ua.zero)                        r = {1'b1, nbs, b[30:0]};
               else if (ub.zero)                        r = {1'b1, a};
            end
            OP_DIV: begin
               if ((ua.inf && ub.inf) || (ua.zero && ub.zero)) r = {1'b1, FP_DEFAULT_NAN};
               else if (ua.inf || ub.zero)                     r = {1'b1, sx, 8'hFF, 23'd0};
               else if (ua.zero || ub.inf)                     r = {1'b1, sx, 31'd0};
            end
            default: r = 33'd0;
         endcase
      end
      return r;
   endfunction

   // Round to nearest even; m[25] is the leading one, m[1] guard, m[0] sticky.
   function automatic logic [31:0] fp_round(input rnd_type r);
      exp_type     b;
      exp_type     sh;
      logic [25:0] sm;
      logic        lost;
      logic [31:0] base;
      logic [31:0] res;
      logic        g;
      logic        s;
      logic        lsb;
      b    = r.e + 11'sd127;
      sh   = 11'sd0;
      sm   = r.m;
      lost = 1'b0;
      base = {r.sgn, b[7:0], r.m[24:2]};
      g    = r.m[1];
      s    = r.m[0];
      lsb  = r.m[2];
      if (b < 11'sd1) begin
         sh = 11'sd1 - b;
         if (sh > 11'sd26) begin
            sm   = 26'd0;
            lost = |r.m;
         end else begin
            sm   = r.m >> sh[4:0];
            lost = |(r.m & ~(26'h3FFFFFF << sh[4:0]));
         end
         base = {r.sgn, 8'd0, sm[24:2]};
         g    = sm[1];
         s    = sm[0] | lost;
         lsb  = sm[2];
      end
      res = base + {31'd0, g & (s | lsb)};
      if (r.spec) res = r.spec_val;
      else if (b >= 11'sd255) res = {r.sgn, 8'hFF, 23'd0};
      return res;
   endfunction

   function automatic dvs_type div_step2(input dvs_type st);
      dvs_type     n;
      logic [24:0] r;
      logic        bt;
      n = st;
      r = st.rem;
      for (int k = 0; k < 2; k++) begin
         bt = (r >= {1'b0, st.dsr});
         if (bt) r = r - {1'b0, st.dsr};
         r   = {r[23:0], 1'b0};
         n.q = {n.q[24:0], bt};
      end
      n.rem = r;
      return n;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/approx_sqrt_newton.sv -----
// Approximate binary32 square root: magic-constant estimate, two Newton steps, reciprocal.
// Depends on asn_pkg and asn_fp_unit.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_value_bits [31:0]
//   rsp      out        rsp_valid/rsp_stall   rsp_root_bits  [31:0]
//
// One transaction per cycle sustained while the skid register is empty.
// The datapath is a chain of ten float units: seven 3-stage multipliers,
// two 5-stage subtractors and a 15-stage divider at two quotient bits per stage.
// Synchronous reset clears only valid bits; there is no clearing pass.
// A skid register behind the output lets the pipeline advance once more under
// rsp_stall; the pipeline holds while the skid register is full.
`default_nettype none

module approx_sqrt_newton (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_root_bits
);

   localparam int N_UNITS = 10;

   logic              adv;
   logic              v_in     [N_UNITS];
   logic [31:0]       a_in     [N_UNITS];
   logic [31:0]       b_in     [N_UNITS];
   asn_pkg::side_type s_in     [N_UNITS];
   logic              v_out    [N_UNITS];
   logic [31:0]       res_out  [N_UNITS];
   asn_pkg::side_type side_out [N_UNITS];

   logic              last_v;
   logic [31:0]       last_bits;
   logic              inc_v;
   logic              pop;
   logic              rsp_v_in, rsp_v_ff, skid_v_in, skid_v_ff;
   logic [31:0]       rsp_bits_in, rsp_bits_ff, skid_bits_in, skid_bits_ff;

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // unit 0: 0.5 * x, carry the integer estimate alongside
   assign v_in[0]   = req_valid;
   assign a_in[0]   = asn_pkg::FP_HALF;
   assign b_in[0]   = req_value_bits;
   assign s_in[0]   = '{zin: (req_value_bits[30:0] == 31'd0),
                        xh:  32'd0,
                        y:   asn_pkg::MAGIC_EST - {req_value_bits[31], req_value_bits[31:1]}};

   // units 1..8: two Newton steps of four operations each
   generate
      for (genvar s = 0; s < 2; s++) begin : g_step
         localparam int B = 1 + 4 * s;

         if (s == 0) begin : g_from_half
            assign s_in[B] = '{zin: side_out[B-1].zin, xh: res_out[B-1], y: side_out[B-1].y};
         end else begin : g_from_step
            assign s_in[B] = '{zin: side_out[B-1].zin, xh: side_out[B-1].xh, y: res_out[B-1]};
         end
         assign v_in[B]   = v_out[B-1];
         assign a_in[B]   = s_in[B].xh;
         assign b_in[B]   = s_in[B].y;

         assign v_in[B+1] = v_out[B];
         assign a_in[B+1] = res_out[B];
         assign b_in[B+1] = side_out[B].y;
         assign s_in[B+1] = side_out[B];

         assign v_in[B+2] = v_out[B+1];
         assign a_in[B+2] = asn_pkg::FP_THREE_HALVES;
         assign b_in[B+2] = res_out[B+1];
         assign s_in[B+2] = side_out[B+1];

         assign v_in[B+3] = v_out[B+2];
         assign a_in[B+3] = side_out[B+2].y;
         assign b_in[B+3] = res_out[B+2];
         assign s_in[B+3] = side_out[B+2];
      end
   endgenerate

   // unit 9: 1.0 / y
   assign v_in[N_UNITS-1] = v_out[N_UNITS-2];
   assign a_in[N_UNITS-1] = asn_pkg::FP_ONE;
   assign b_in[N_UNITS-1] = res_out[N_UNITS-2];
   assign s_in[N_UNITS-1] = side_out[N_UNITS-2];

   generate
      for (genvar i = 0; i < N_UNITS; i++) begin : g_unit
         asn_fp_unit #(
            .OP((i == N_UNITS - 1) ? asn_pkg::OP_DIV :
                ((i % 4 == 3) ? asn_pkg::OP_SUB : asn_pkg::OP_MUL))
         ) u_fp (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .in_valid (v_in[i]),
            .in_a     (a_in[i]),
            .in_b     (b_in[i]),
            .in_side  (s_in[i]),
            .out_valid(v_out[i]),
            .out_res  (res_out[i]),
            .out_side (side_out[i])
         );
      end
   endgenerate

   assign last_v    = v_out[N_UNITS-1];
   assign last_bits = side_out[N_UNITS-1].zin ? 32'd0 : res_out[N_UNITS-1];
   assign inc_v     = last_v && adv;
   assign pop       = rsp_v_ff && !rsp_stall;

   // output register with skid
   always_comb begin
      rsp_v_in     = rsp_v_ff;
      rsp_bits_in  = rsp_bits_ff;
      skid_v_in    = skid_v_ff;
      skid_bits_in = skid_bits_ff;
      if (!rsp_v_ff || pop) begin
         if (skid_v_ff) begin
            rsp_v_in    = 1'b1;
            rsp_bits_in = skid_bits_ff;
            skid_v_in   = 1'b0;
         end else begin
            rsp_v_in    = inc_v;
            rsp_bits_in = last_bits;
         end
      end else if (inc_v) begin
         skid_v_in    = 1'b1;
         skid_bits_in = last_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bits_ff  <= rsp_bits_in;
      skid_bits_ff <= skid_bits_in;
   end

   assign rsp_valid     = rsp_v_ff;
   assign rsp_root_bits = rsp_bits_ff;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> rsp_v_ff)
      else $error("skid register holds a transaction while the output is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_v_ff) |-> $past(rsp_v_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_stall && skid_v_ff) |=> (rsp_v_ff && !skid_v_ff))
      else $error("skid register not moved to the output after a transfer");

endmodule

`default_nettype wire

// ----- rtl/asn_fp_unit.sv -----
// Pipelined binary32 unit: multiply, subtract (a - b) or divide (a / b), round to nearest even.
// Depends on asn_pkg; all stages advance together on adv.
`default_nettype none

module asn_fp_unit #(
   parameter asn_pkg::op_kind_type OP = asn_pkg::OP_MUL
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [31:0]        in_a,
   input  logic [31:0]        in_b,
   input  asn_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [31:0]        out_res,
   output asn_pkg::side_type  out_side
);

   // unpack stage
   asn_pkg::unp_type  ua_in, ub_in, ua_ff, ub_ff;
   logic [32:0]       sp_in, sp_ff;
   logic              u_v_ff;
   asn_pkg::side_type u_side_ff;

   logic              rnd_v;
   asn_pkg::side_type rnd_side;
   asn_pkg::rnd_type  rnd;

   logic              out_v_ff;
   logic [31:0]       res_in, res_ff;
   asn_pkg::side_type out_side_ff;

   always_comb begin
      ua_in = asn_pkg::fp_unpack(in_a);
      ub_in = asn_pkg::fp_unpack(in_b);
      sp_in = asn_pkg::fp_special(OP, in_a, in_b, ua_in, ub_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_v_ff <= 1'b0;
      end else if (adv) begin
         u_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ua_ff     <= ua_in;
         ub_ff     <= ub_in;
         sp_ff     <= sp_in;
         u_side_ff <= in_side;
      end
   end

   generate
      if (OP == asn_pkg::OP_MUL) begin : g_mul
         logic [47:0]       p_in, p_ff;
         asn_pkg::exp_type  e_in, e_ff;
         logic              sg_ff;
         logic [32:0]       ps_ff;
         logic              p_v_ff;
         asn_pkg::side_type p_side_ff;

         assign p_in = ua_ff.sig * ub_ff.sig;
         assign e_in = ua_ff.e + ub_ff.e;

         always_ff @(posedge clock) begin
            if (reset) begin
               p_v_ff <= 1'b0;
            end else if (adv) begin
               p_v_ff <= u_v_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               p_ff      <= p_in;
               e_ff      <= e_in;
               sg_ff     <= ua_ff.sgn ^ ub_ff.sgn;
               ps_ff     <= sp_ff;
               p_side_ff <= u_side_ff;
            end
         end

         always_comb begin
            rnd.spec     = ps_ff[32];
            rnd.spec_val = ps_ff[31:0];
            rnd.sgn      = sg_ff;
            if (p_ff[47]) begin
               rnd.m = {p_ff[47:23], |p_ff[22:0]};
               rnd.e = e_ff + 11'sd1;
            end else begin
               rnd.m = {p_ff[46:22], |p_ff[21:0]};
               rnd.e = e_ff;
            end
         end

         assign rnd_v    = p_v_ff;
         assign rnd_side = p_side_ff;
      end else if (OP == asn_pkg::OP_SUB) begin : g_sub
         // swap stage
         logic              a_big;
         logic [23:0]       big_sig_in, big_sig_ff, sml_sig_in, sml_sig_ff;
         asn_pkg::exp_type  big_e_in, big_e_ff, d_in, d_ff;
         logic              sub_in, sub_ff, sg_in, sg_ff;
         logic [32:0]       s_sp_ff;
         logic              s_v_ff;
         asn_pkg::side_type s_side_ff;
         // add stage
         logic [26:0]       sml27, al27;
         logic [27:0]       sum_in, sum_ff;
         asn_pkg::exp_type  a_e_ff;
         logic              a_sg_ff;
         logic [32:0]       a_sp_ff;
         logic              a_v_ff;
         asn_pkg::side_type a_side_ff;
         // normalise stage
         logic [4:0]        lz;
         logic [27:0]       norm;
         asn_pkg::rnd_type  n_in, n_ff;
         logic              n_v_ff;
         asn_pkg::side_type n_side_ff;

         always_comb begin
            a_big = (ua_ff.e > ub_ff.e) ||
                    ((ua_ff.e == ub_ff.e) && (ua_ff.sig >= ub_ff.sig));
            big_sig_in = a_big ? ua_ff.sig : ub_ff.sig;
            sml_sig_in = a_big ? ub_ff.sig : ua_ff.sig;
            big_e_in   = a_big ? ua_ff.e : ub_ff.e;
            d_in       = a_big ? (ua_ff.e - ub_ff.e) : (ub_ff.e - ua_ff.e);
            // b enters negated
            sub_in     = (ua_ff.sgn == ub_ff.sgn);
            sg_in      = a_big ? ua_ff.sgn : ~ub_ff.sgn;
         end

         always_comb begin
            sml27 = {sml_sig_ff, 3'b000};
            if (d_ff > 11'sd26) begin
               al27 = 27'd1;
            end else begin
               al27 = (sml27 >> d_ff[4:0]) |
                      {26'd0, |(sml27 & ~(27'h7FFFFFF << d_ff[4:0]))};
            end
            if (sub_ff) sum_in = {1'b0, big_sig_ff, 3'b000} - {1'b0, al27};
            else        sum_in = {1'b0, big_sig_ff, 3'b000} + {1'b0, al27};
         end

         always_comb begin
            lz            = asn_pkg::lzc28(sum_ff);
            norm          = sum_ff << lz;
            n_in.sgn      = a_sg_ff;
            n_in.e        = a_e_ff + 11'sd1 - asn_pkg::exp_type'({6'd0, lz});
            n_in.m        = {norm[27:3], |norm[2:0]};
            n_in.spec     = a_sp_ff[32];
            n_in.spec_val = a_sp_ff[31:0];
            // exact cancellation gives +0
            if (!a_sp_ff[32] && (sum_ff == 28'd0)) begin
               n_in.spec     = 1'b1;
               n_in.spec_val = 32'd0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               s_v_ff <= 1'b0;
               a_v_ff <= 1'b0;
               n_v_ff <= 1'b0;
            end else if (adv) begin
               s_v_ff <= u_v_ff;
               a_v_ff <= s_v_ff;
               n_v_ff <= a_v_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               big_sig_ff <= big_sig_in;
               sml_sig_ff <= sml_sig_in;
               big_e_ff   <= big_e_in;
               d_ff       <= d_in;
               sub_ff     <= sub_in;
               sg_ff      <= sg_in;
               s_sp_ff    <= sp_ff;
               s_side_ff  <= u_side_ff;
               sum_ff     <= sum_in;
               a_e_ff     <= big_e_ff;
               a_sg_ff    <= sg_ff;
               a_sp_ff    <= s_sp_ff;
               a_side_ff  <= s_side_ff;
               n_ff       <= n_in;
               n_side_ff  <= a_side_ff;
            end
         end

         assign rnd      = n_ff;
         assign rnd_v    = n_v_ff;
         assign rnd_side = n_side_ff;
      end else begin : g_div
         logic              ge;
         asn_pkg::dvs_type  dv_init;
         asn_pkg::dvs_type  dv_in   [asn_pkg::DIV_STAGES];
         asn_pkg::dvs_type  dv_ff   [asn_pkg::DIV_STAGES];
         logic              dv_v_ff [asn_pkg::DIV_STAGES];
         asn_pkg::side_type dv_side_ff [asn_pkg::DIV_STAGES];

         always_comb begin
            ge               = (ua_ff.sig >= ub_ff.sig);
            dv_init.spec     = sp_ff[32];
            dv_init.spec_val = sp_ff[31:0];
            dv_init.sgn      = ua_ff.sgn ^ ub_ff.sgn;
            dv_init.e        = ua_ff.e - ub_ff.e - (ge ? 11'sd0 : 11'sd1);
            dv_init.dsr      = ub_ff.sig;
            dv_init.rem      = ge ? {1'b0, ua_ff.sig} : {ua_ff.sig, 1'b0};
            dv_init.q        = 26'd0;
         end

         for (genvar k = 0; k < asn_pkg::DIV_STAGES; k++) begin : g_stage
            if (k == 0) begin : g_first
               assign dv_in[k] = asn_pkg::div_step2(dv_init);

               always_ff @(posedge clock) begin
                  if (reset) begin
                     dv_v_ff[k] <= 1'b0;
                  end else if (adv) begin
                     dv_v_ff[k] <= u_v_ff;
                  end
               end

               always_ff @(posedge clock) begin
                  if (adv) begin
                     dv_ff[k]      <= dv_in[k];
                     dv_side_ff[k] <= u_side_ff;
                  end
               end
            end else begin : g_next
               assign dv_in[k] = asn_pkg::div_step2(dv_ff[k-1]);

               always_ff @(posedge clock) begin
                  if (reset) begin
                     dv_v_ff[k] <= 1'b0;
                  end else if (adv) begin
                     dv_v_ff[k] <= dv_v_ff[k-1];
                  end
               end

               always_ff @(posedge clock) begin
                  if (adv) begin
                     dv_ff[k]      <= dv_in[k];
                     dv_side_ff[k] <= dv_side_ff[k-1];
                  end
               end
            end
         end

         always_comb begin
            rnd.spec     = dv_ff[asn_pkg::DIV_STAGES-1].spec;
            rnd.spec_val = dv_ff[asn_pkg::DIV_STAGES-1].spec_val;
            rnd.sgn      = dv_ff[asn_pkg::DIV_STAGES-1].sgn;
            rnd.e        = dv_ff[asn_pkg::DIV_STAGES-1].e;
            rnd.m        = {dv_ff[asn_pkg::DIV_STAGES-1].q[25:1],
                            dv_ff[asn_pkg::DIV_STAGES-1].q[0] |
                            (|dv_ff[asn_pkg::DIV_STAGES-1].rem)};
         end

         assign rnd_v    = dv_v_ff[asn_pkg::DIV_STAGES-1];
         assign rnd_side = dv_side_ff[asn_pkg::DIV_STAGES-1];
      end
   endgenerate

   // round and register
   assign res_in = asn_pkg::fp_round(rnd);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= rnd_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff      <= res_in;
         out_side_ff <= rnd_side;
      end
   end

   assign out_valid = out_v_ff;
   assign out_res   = res_ff;
   assign out_side  = out_side_ff;

endmodule

`default_nettype wire
